// ----- rtl/pdws_pkg.sv -----
// Package for the position drive regulator: field widths, fixed-point constants,
// register codes, reset values and shared types.
// No dependencies; every other file of the block depends on this package.
package pdws_pkg;

    // Field widths of the input, result and register words.
    localparam int POS_W      = 28;
    localparam int GAIN_W     = 20;
    localparam int SLEW_W     = 17;
    localparam int LIMIT_W    = 20;
    localparam int SETTLE_W   = 16;
    localparam int MV_W       = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int INPUT_POS_COUNT = 6;

    // Motor count and the averaging divisor derived from it.
    localparam int MOTOR_COUNT = 6;
    localparam int AVG_COUNT   = (MOTOR_COUNT > INPUT_POS_COUNT) ? INPUT_POS_COUNT :
                                 ((MOTOR_COUNT < 1) ? 1 : MOTOR_COUNT);
    localparam int SUM_W       = POS_W + $clog2(AVG_COUNT);

    // Reciprocal for the truncating average: q0 = (|sum| * RECIP_M) >> RECIP_K
    // is the quotient or one below it, fixed by one compare afterwards.
    localparam int RECIP_K = SUM_W;
    localparam int RECIP_W = RECIP_K + 1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_K) / AVG_COUNT);
    localparam int RECIP_PROD_W = SUM_W + RECIP_W;

    // Internal arithmetic widths.
    localparam int ERR_W  = POS_W + 1;
    localparam int DER_W  = ERR_W + 1;
    localparam int ISUM_W = 32;
    localparam int ACC_W  = GAIN_W + 1 + ISUM_W + 2;
    localparam int PWR_W  = 18;
    localparam int FRAC_SHIFT = 4;

    // Q16 power and millivolt scaling.
    localparam int POWER_ONE   = 65536;
    localparam int MV_SCALE    = 11000;
    localparam int MV_PROD_W   = 32;
    localparam int ROUND_SHIFT = 16;
    localparam int ROUND_HALF  = 32768;

    // Item command codes.
    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P            = 3'd0,
        REG_GAIN_I            = 3'd1,
        REG_GAIN_D            = 3'd2,
        REG_SLEW_STEP         = 3'd3,
        REG_INTEGRAL_LIMIT    = 3'd4,
        REG_SETTLE_ERROR      = 3'd5,
        REG_SETTLE_PREV_ERROR = 3'd6
    } cfg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [SLEW_W-1:0]   slew_step;
        logic [LIMIT_W-1:0]  integral_limit;
        logic [SETTLE_W-1:0] settle_error;
        logic [SETTLE_W-1:0] settle_prev_error;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:            GAIN_W'(3375),
        gain_i:            GAIN_W'(754),
        gain_d:            GAIN_W'(32768),
        slew_step:         SLEW_W'(6554),
        integral_limit:    LIMIT_W'(3200),
        settle_error:      SETTLE_W'(12),
        settle_prev_error: SETTLE_W'(16)
    };

    // Kind of word travelling through the back half of the pipeline.
    typedef struct packed {
        logic is_begin;
        logic active;
        logic done;
    } item_flags_t;

endpackage

// ----- rtl/pdws_in_if.sv -----
// Input channel of the position drive regulator: valid/ready plus the item word.
// Depends on pdws_pkg for field widths.
interface pdws_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic signed [pdws_pkg::POS_W-1:0] target;
    logic signed [pdws_pkg::POS_W-1:0] pos_front_left;
    logic signed [pdws_pkg::POS_W-1:0] pos_front_right;
    logic signed [pdws_pkg::POS_W-1:0] pos_mid_left;
    logic signed [pdws_pkg::POS_W-1:0] pos_mid_right;
    logic signed [pdws_pkg::POS_W-1:0] pos_back_left;
    logic signed [pdws_pkg::POS_W-1:0] pos_back_right;

    modport source (
        output valid, command, target, pos_front_left, pos_front_right,
               pos_mid_left, pos_mid_right, pos_back_left, pos_back_right,
        input  ready
    );
    modport sink (
        input  valid, command, target, pos_front_left, pos_front_right,
               pos_mid_left, pos_mid_right, pos_back_left, pos_back_right,
        output ready
    );
endinterface

// ----- rtl/pdws_out_if.sv -----
// Result channel of the position drive regulator: valid/ready plus the result word.
// Depends on pdws_pkg for field widths.
interface pdws_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pdws_pkg::MV_W-1:0] drive_millivolts;
    logic                             done_res;

    modport source (
        output valid, drive_millivolts, done_res,
        input  ready
    );
    modport sink (
        input  valid, drive_millivolts, done_res,
        output ready
    );
endinterface

// ----- rtl/pdws_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on pdws_pkg for widths.
interface pdws_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pdws_pkg::CFG_IDX_W-1:0]    index;
    logic [pdws_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/pid_position_drive_with_slew_unit.sv -----
// Position PID drive regulator with output clamp and slew limit.
// Throughput: one word per cycle; each stage advances into a free slot, so a
// stalled result blocks the input only once all nine stages hold words.
// Reset: valids cleared, registers at their reset values, controller state
// zero and the finished flag set, so ticks report done until a begin word.
// Depends on pdws_pkg and the interfaces pdws_in_if, pdws_out_if, pdws_cfg_if.
module pid_position_drive_with_slew_unit (
    input logic      clk,
    input logic      rst_n,
    pdws_in_if.sink  in_ch,
    pdws_cfg_if.sink cfg_ch,
    pdws_out_if.source out_ch
);
    import pdws_pkg::*;

    localparam int NSTAGE = 9;

    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(POWER_ONE);
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(POWER_ONE);
    localparam logic signed [MV_PROD_W-1:0] MV_SCALE_S = MV_PROD_W'(MV_SCALE);

    // Configuration registers.
    cfg_t cfg_reg;

    // Pipeline valids and per-stage advance enables.
    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] adv;

    // Stage payloads.
    logic                    s1_cmd_reg;
    logic signed [POS_W-1:0] s1_target_reg;
    logic signed [POS_W-1:0] s1_pos_reg [AVG_COUNT];
    logic signed [POS_W-1:0] pos_in [INPUT_POS_COUNT];

    logic                    s2_cmd_reg;
    logic signed [POS_W-1:0] s2_target_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic signed [SUM_W-1:0] s2_sum_next;

    logic                    s3_cmd_reg;
    logic signed [POS_W-1:0] s3_target_reg;
    logic [SUM_W-1:0]        s3_mag_reg;
    logic [SUM_W-1:0]        s3_mag_next;
    logic [SUM_W-1:0]        s3_quo_reg;
    logic                    s3_neg_reg;
    logic [RECIP_PROD_W-1:0] recip_prod;

    logic                    s4_cmd_reg;
    logic signed [POS_W-1:0] s4_target_reg;
    logic signed [POS_W-1:0] s4_avg_reg;
    logic signed [POS_W-1:0] s4_avg_next;
    logic [SUM_W-1:0]        quo_rem;
    logic [SUM_W-1:0]        quo_fixed;
    logic signed [SUM_W:0]   avg_wide;

    // Controller state.
    logic signed [POS_W-1:0]  target_reg;
    logic signed [ISUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [PWR_W-1:0]  last_power_reg;
    logic                     finished_reg;

    // Stage 5 (error, integral, settle test).
    logic signed [ERR_W-1:0]  err_next;
    logic [ERR_W-1:0]         err_mag;
    logic [ERR_W-1:0]         last_err_mag;
    logic [ISUM_W-1:0]        isum_mag;
    logic signed [ISUM_W:0]   isum_wide;
    logic signed [ISUM_W-1:0] isum_sat;
    logic signed [ISUM_W-1:0] isum_next;
    logic signed [DER_W-1:0]  deriv_next;
    logic                     settled;
    logic                     go5;
    logic signed [ERR_W-1:0]  s5_err_reg;
    logic signed [ISUM_W-1:0] s5_isum_reg;
    logic signed [DER_W-1:0]  s5_deriv_reg;
    item_flags_t              s5_flags_reg;
    item_flags_t              s5_flags_next;

    // Stage 6 (gain products).
    logic signed [GAIN_W:0]   gp_s;
    logic signed [GAIN_W:0]   gi_s;
    logic signed [GAIN_W:0]   gd_s;
    logic signed [ACC_W-1:0]  s6_p_reg;
    logic signed [ACC_W-1:0]  s6_i_reg;
    logic signed [ACC_W-1:0]  s6_d_reg;
    item_flags_t              s6_flags_reg;

    // Stage 7 (sum, floor to Q16, clamp to one).
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_q16;
    logic signed [ACC_W-1:0]  acc_clamped;
    logic signed [PWR_W-1:0]  s7_raw_reg;
    item_flags_t              s7_flags_reg;

    // Stage 8 (slew limit).
    logic signed [PWR_W:0]    slew_s;
    logic signed [PWR_W:0]    lp_ext;
    logic signed [PWR_W:0]    pwr_hi;
    logic signed [PWR_W:0]    pwr_lo;
    logic signed [PWR_W:0]    raw_ext;
    logic signed [PWR_W:0]    pwr_lim;
    logic signed [PWR_W-1:0]  power_next;
    logic                     go8;
    logic signed [PWR_W-1:0]  s8_power_reg;
    item_flags_t              s8_flags_reg;

    // Stage 9 (millivolt scaling) and the result register.
    logic signed [MV_PROD_W-1:0] mv_prod;
    logic [MV_PROD_W-1:0]        mv_abs;
    logic [MV_PROD_W-1:0]        mv_round;
    logic [MV_W-1:0]             mv_mag;
    logic signed [MV_W-1:0]      mv_next;
    logic signed [MV_W-1:0]      out_drive_reg;
    logic                        out_done_reg;

    // Configuration writes; unknown indexes are dropped.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_index_t'(cfg_ch.index))
                REG_GAIN_P:            cfg_reg.gain_p <= cfg_ch.data[GAIN_W-1:0];
                REG_GAIN_I:            cfg_reg.gain_i <= cfg_ch.data[GAIN_W-1:0];
                REG_GAIN_D:            cfg_reg.gain_d <= cfg_ch.data[GAIN_W-1:0];
                REG_SLEW_STEP:         cfg_reg.slew_step <= cfg_ch.data[SLEW_W-1:0];
                REG_INTEGRAL_LIMIT:    cfg_reg.integral_limit <= cfg_ch.data[LIMIT_W-1:0];
                REG_SETTLE_ERROR:      cfg_reg.settle_error <= cfg_ch.data[SETTLE_W-1:0];
                REG_SETTLE_PREV_ERROR: cfg_reg.settle_prev_error <= cfg_ch.data[SETTLE_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        adv[NSTAGE] = !vld_reg[NSTAGE] || out_ch.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ch.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= in_ch.valid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: input register.
    assign pos_in[0] = in_ch.pos_front_left;
    assign pos_in[1] = in_ch.pos_front_right;
    assign pos_in[2] = in_ch.pos_mid_left;
    assign pos_in[3] = in_ch.pos_mid_right;
    assign pos_in[4] = in_ch.pos_back_left;
    assign pos_in[5] = in_ch.pos_back_right;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_cmd_reg    <= in_ch.command;
            s1_target_reg <= in_ch.target;
            for (int i = 0; i < AVG_COUNT; i++)
            begin
                s1_pos_reg[i] <= pos_in[i];
            end
        end
    end

    // Stage 2: sum of the encoder positions.
    always_comb
    begin
        s2_sum_next = '0;
        for (int i = 0; i < AVG_COUNT; i++)
        begin
            s2_sum_next = s2_sum_next + SUM_W'(s1_pos_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_target_reg <= s1_target_reg;
            s2_sum_reg    <= s2_sum_next;
        end
    end

    // Stage 3: magnitude of the sum times the reciprocal of the count.
    assign s3_mag_next = s2_sum_reg[SUM_W-1] ? SUM_W'(-s2_sum_reg) : SUM_W'(s2_sum_reg);
    assign recip_prod  = RECIP_PROD_W'(s3_mag_next) * RECIP_PROD_W'(RECIP_M);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_cmd_reg    <= s2_cmd_reg;
            s3_target_reg <= s2_target_reg;
            s3_mag_reg    <= s3_mag_next;
            s3_quo_reg    <= recip_prod[RECIP_K +: SUM_W];
            s3_neg_reg    <= s2_sum_reg[SUM_W-1];
        end
    end

    // Stage 4: fix the estimate by one and restore the sign (truncates toward zero).
    assign quo_rem   = s3_mag_reg - s3_quo_reg * SUM_W'(AVG_COUNT);
    assign quo_fixed = s3_quo_reg + SUM_W'(quo_rem >= SUM_W'(AVG_COUNT));
    assign avg_wide  = s3_neg_reg ? -signed'({1'b0, quo_fixed}) : signed'({1'b0, quo_fixed});
    assign s4_avg_next = avg_wide[POS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_cmd_reg    <= s3_cmd_reg;
            s4_target_reg <= s3_target_reg;
            s4_avg_reg    <= s4_avg_next;
        end
    end

    // Stage 5: error, saturating integral, derivative and the settle test.
    assign go5          = adv[5] && vld_reg[4];
    assign err_next     = ERR_W'(target_reg) - ERR_W'(s4_avg_reg);
    assign err_mag      = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
    assign last_err_mag = last_error_reg[ERR_W-1] ? ERR_W'(-last_error_reg)
                                                  : ERR_W'(last_error_reg);
    assign isum_mag     = error_sum_reg[ISUM_W-1] ? ISUM_W'(-error_sum_reg)
                                                  : ISUM_W'(error_sum_reg);
    assign isum_wide    = (ISUM_W+1)'(error_sum_reg) + (ISUM_W+1)'(err_next);
    assign deriv_next   = DER_W'(err_next) - DER_W'(last_error_reg);
    assign settled      = (err_mag < ERR_W'(cfg_reg.settle_error))
                       && (last_err_mag < ERR_W'(cfg_reg.settle_prev_error));

    always_comb
    begin
        priority if (isum_wide[ISUM_W] != isum_wide[ISUM_W-1])
        begin
            isum_sat = isum_wide[ISUM_W] ? {1'b1, {(ISUM_W-1){1'b0}}}
                                         : {1'b0, {(ISUM_W-1){1'b1}}};
        end
        else
        begin
            isum_sat = isum_wide[ISUM_W-1:0];
        end
        isum_next = (isum_mag < ISUM_W'(cfg_reg.integral_limit)) ? isum_sat : error_sum_reg;
    end

    // Word kind after stage 5: a begin, an idle tick, a settling tick or a live tick.
    always_comb
    begin
        s5_flags_next = '0;
        priority if (s4_cmd_reg == CMD_BEGIN)
        begin
            s5_flags_next.is_begin = 1'b1;
        end
        else if (finished_reg || settled)
        begin
            s5_flags_next.done = 1'b1;
        end
        else
        begin
            s5_flags_next.active = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            finished_reg   <= 1'b1;
        end
        else if (go5)
        begin
            if (s4_cmd_reg == CMD_BEGIN)
            begin
                target_reg     <= s4_target_reg;
                error_sum_reg  <= '0;
                last_error_reg <= '0;
                finished_reg   <= 1'b0;
            end
            else if (!finished_reg)
            begin
                error_sum_reg <= isum_next;
                if (settled)
                begin
                    finished_reg <= 1'b1;
                end
                else
                begin
                    last_error_reg <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_err_reg   <= err_next;
            s5_isum_reg  <= isum_next;
            s5_deriv_reg <= deriv_next;
            s5_flags_reg <= s5_flags_next;
        end
    end

    // Stage 6: the three gain products.
    assign gp_s = signed'({1'b0, cfg_reg.gain_p});
    assign gi_s = signed'({1'b0, cfg_reg.gain_i});
    assign gd_s = signed'({1'b0, cfg_reg.gain_d});

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_p_reg     <= ACC_W'(gp_s) * ACC_W'(s5_err_reg);
            s6_i_reg     <= ACC_W'(gi_s) * ACC_W'(s5_isum_reg);
            s6_d_reg     <= ACC_W'(gd_s) * ACC_W'(s5_deriv_reg);
            s6_flags_reg <= s5_flags_reg;
        end
    end

    // Stage 7: sum, floor division by 16, clamp to plus or minus one in Q16.
    assign acc_sum = s6_p_reg + s6_i_reg + s6_d_reg;
    assign acc_q16 = acc_sum >>> FRAC_SHIFT;

    always_comb
    begin
        priority if (acc_q16 > ACC_HI)
        begin
            acc_clamped = ACC_HI;
        end
        else if (acc_q16 < ACC_LO)
        begin
            acc_clamped = ACC_LO;
        end
        else
        begin
            acc_clamped = acc_q16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_raw_reg   <= acc_clamped[PWR_W-1:0];
            s7_flags_reg <= s6_flags_reg;
        end
    end

    // Stage 8: keep the power within one slew step of the previous power.
    assign go8     = adv[8] && vld_reg[7];
    assign slew_s  = signed'((PWR_W+1)'(cfg_reg.slew_step));
    assign lp_ext  = (PWR_W+1)'(last_power_reg);
    assign raw_ext = (PWR_W+1)'(s7_raw_reg);
    assign pwr_hi  = lp_ext + slew_s;
    assign pwr_lo  = lp_ext - slew_s;

    always_comb
    begin
        priority if (raw_ext > pwr_hi)
        begin
            pwr_lim = pwr_hi;
        end
        else if (raw_ext < pwr_lo)
        begin
            pwr_lim = pwr_lo;
        end
        else
        begin
            pwr_lim = raw_ext;
        end
        power_next = pwr_lim[PWR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_power_reg <= '0;
        end
        else if (go8)
        begin
            if (s7_flags_reg.is_begin)
            begin
                last_power_reg <= '0;
            end
            else if (s7_flags_reg.active)
            begin
                last_power_reg <= power_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s8_power_reg <= power_next;
            s8_flags_reg <= s7_flags_reg;
        end
    end

    // Stage 9: millivolts of the supply, rounded half away from zero.
    assign mv_prod  = MV_PROD_W'(s8_power_reg) * MV_SCALE_S;
    assign mv_abs   = mv_prod[MV_PROD_W-1] ? MV_PROD_W'(-mv_prod) : MV_PROD_W'(mv_prod);
    assign mv_round = mv_abs + MV_PROD_W'(ROUND_HALF);
    assign mv_mag   = mv_round[ROUND_SHIFT +: MV_W];
    assign mv_next  = mv_prod[MV_PROD_W-1] ? -signed'(mv_mag) : signed'(mv_mag);

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            out_drive_reg <= s8_flags_reg.active ? mv_next : '0;
            out_done_reg  <= s8_flags_reg.done;
        end
    end

    assign out_ch.valid            = vld_reg[NSTAGE];
    assign out_ch.drive_millivolts = out_drive_reg;
    assign out_ch.done_res         = out_done_reg;

    // A done word never drives the motors.
    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.done_res) |-> (out_ch.drive_millivolts == '0))
        else $error("done result carries a nonzero drive");

    // The drive stays within the supply range.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.drive_millivolts <= MV_W'(MV_SCALE))
                       && (out_ch.drive_millivolts >= -MV_W'(MV_SCALE))))
        else $error("drive outside the supply range");

    // The stored power never leaves plus or minus one.
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        (last_power_reg <= PWR_W'(POWER_ONE)) && (last_power_reg >= -PWR_W'(POWER_ONE)))
        else $error("stored power out of range");

    // The input is held off only while the first stage holds a word.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> vld_reg[1])
        else $error("input stalled with an empty first stage");

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the position drive regulator: drives begin and tick words, predicts
// drive millivolts and the done flag, and checks every result word in order.
// Depends on pdws_pkg, the pdws_in_if/pdws_out_if/pdws_cfg_if interfaces and the unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdws_pkg::*;

    // Index that decodes to no register; writes to it must leave everything unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_INDEX = 3'd7;

    localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
    localparam int      LONG_STALL_CYCLES = 300;
    localparam int      SETTLE_CYCLES     = 20;

    // One input word as queued for the driver.
    typedef struct packed {
        command_t                               command;
        logic [POS_W-1:0]                       target;
        logic [INPUT_POS_COUNT-1:0][POS_W-1:0]  pos;
    } drive_item_t;

    // One result word as predicted or observed.
    typedef struct packed {
        logic signed [MV_W-1:0] millivolts;
        logic                   done;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pdws_in_if  in_ch();
    pdws_cfg_if cfg_ch();
    pdws_out_if out_ch();

    pid_position_drive_with_slew_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Words waiting for the driver, and results waiting for the output.
    drive_item_t   move_item_q[$];
    drive_result_t drive_expect_q[$];

    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int          mismatches   = 0;
    logic        in_accepted  = 1'b0;
    logic        cfg_accepted = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_requests = 0;
    int stall_seen     = 0;
    int stall_left     = 0;

    // Shadow copy of the registers and of the controller state.
    cfg_t                     reg_shadow   = CFG_RESET;
    logic signed [POS_W-1:0]  move_target  = '0;
    logic signed [ISUM_W-1:0] integral     = '0;
    logic signed [ERR_W-1:0]  prev_error   = '0;
    logic signed [PWR_W-1:0]  prev_power   = '0;
    logic                     settled      = 1'b1;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Expected result of one accepted word; advances the shadow state.
    function automatic drive_result_t regulate_step(drive_item_t it);
        longint        pos_total;
        longint        avg;
        longint        err;
        longint        deriv;
        longint        acc;
        longint        pwr;
        longint        bound;
        longint        scaled;
        longint        mv;
        int            cnt;
        drive_result_t r;
        r.millivolts = '0;
        r.done       = 1'b0;
        if (it.command == CMD_BEGIN)
        begin
            move_target = it.target;
            integral    = '0;
            prev_error  = '0;
            prev_power  = '0;
            settled     = 1'b0;
            return r;
        end
        if (settled)
        begin
            r.done = 1'b1;
            return r;
        end

        // Average of the encoder positions, truncated toward zero.
        cnt = (MOTOR_COUNT > INPUT_POS_COUNT) ? INPUT_POS_COUNT :
              ((MOTOR_COUNT < 1) ? 1 : MOTOR_COUNT);
        pos_total = 0;
        for (int i = 0; i < cnt; i++)
            pos_total += longint'(signed'(it.pos[i]));
        avg = pos_total / cnt;
        err = longint'(move_target) - avg;

        // The integral only changes while its magnitude is under the limit.
        if (mag(longint'(integral)) < longint'(reg_shadow.integral_limit))
        begin
            acc = longint'(integral) + err;
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            integral = acc[ISUM_W-1:0];
        end
        deriv = err - longint'(prev_error);

        acc = longint'(reg_shadow.gain_p) * err
            + longint'(reg_shadow.gain_i) * longint'(integral)
            + longint'(reg_shadow.gain_d) * deriv;
        pwr = acc >>> FRAC_SHIFT;

        // Clamp to full scale, then to the slew window around the last power.
        if (pwr > POWER_ONE)
            pwr = POWER_ONE;
        if (pwr < -POWER_ONE)
            pwr = -POWER_ONE;
        bound = longint'(prev_power) + longint'(reg_shadow.slew_step);
        if (pwr > bound)
            pwr = bound;
        bound = longint'(prev_power) - longint'(reg_shadow.slew_step);
        if (pwr < bound)
            pwr = bound;

        // Settled: report done and keep the previous power and error.
        if (mag(err) < longint'(reg_shadow.settle_error) &&
            mag(longint'(prev_error)) < longint'(reg_shadow.settle_prev_error))
        begin
            settled = 1'b1;
            r.done  = 1'b1;
            return r;
        end
        prev_power = pwr[PWR_W-1:0];
        prev_error = err[ERR_W-1:0];

        // Millivolts of the 11 V supply, rounded half away from zero.
        scaled = longint'(MV_SCALE) * pwr;
        if (scaled >= 0)
            mv = (scaled + ROUND_HALF) / POWER_ONE;
        else
            mv = -((-scaled + ROUND_HALF) / POWER_ONE);
        r.millivolts = mv[MV_W-1:0];
        return r;
    endfunction

    // Sender: offers the next queued word, idling at random.
    always @(negedge clk)
    begin : send_words
        drive_item_t nxt;
        if (!in_ch.valid || in_accepted)
        begin
            if (move_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = move_item_q.pop_front();
                in_ch.valid           <= 1'b1;
                in_ch.command         <= nxt.command;
                in_ch.target          <= nxt.target;
                in_ch.pos_front_left  <= nxt.pos[0];
                in_ch.pos_front_right <= nxt.pos[1];
                in_ch.pos_mid_left    <= nxt.pos[2];
                in_ch.pos_mid_right   <= nxt.pos[3];
                in_ch.pos_back_left   <= nxt.pos[4];
                in_ch.pos_back_right  <= nxt.pos[5];
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin : take_results
        if (stall_requests != stall_seen)
        begin
            stall_seen = stall_requests;
            stall_left = LONG_STALL_CYCLES;
        end
        if (stall_left != 0)
        begin
            stall_left    = stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks each result word, then predicts for each accepted input word.
    always @(posedge clk)
    begin : watch_ports
        drive_result_t want;
        drive_item_t   seen_item;
        in_accepted  <= rst_n && in_ch.valid && in_ch.ready;
        cfg_accepted <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                $error("result word with none expected: drive_millivolts %0d done_res %0b",
                       out_ch.drive_millivolts, out_ch.done_res);
                mismatches++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (out_ch.drive_millivolts !== want.millivolts)
                begin
                    $error("drive_millivolts: expected %0d, got %0d",
                           want.millivolts, out_ch.drive_millivolts);
                    mismatches++;
                end
                if (out_ch.done_res !== want.done)
                begin
                    $error("done_res: expected %0b, got %0b", want.done, out_ch.done_res);
                    mismatches++;
                end
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            seen_item.command = command_t'(in_ch.command);
            seen_item.target  = in_ch.target;
            seen_item.pos[0]  = in_ch.pos_front_left;
            seen_item.pos[1]  = in_ch.pos_front_right;
            seen_item.pos[2]  = in_ch.pos_mid_left;
            seen_item.pos[3]  = in_ch.pos_mid_right;
            seen_item.pos[4]  = in_ch.pos_back_left;
            seen_item.pos[5]  = in_ch.pos_back_right;
            drive_expect_q.push_back(regulate_step(seen_item));
            items_taken++;
        end
    end

    function automatic logic [POS_W-1:0] fit_pos(longint v);
        if (v > POS_MAX)
            v = POS_MAX;
        if (v < POS_MIN)
            v = POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] any_pos();
        return POS_W'($urandom());
    endfunction

    function automatic drive_item_t begin_item(longint tgt);
        drive_item_t it;
        it.command = CMD_BEGIN;
        it.target  = fit_pos(tgt);
        for (int i = 0; i < INPUT_POS_COUNT; i++)
            it.pos[i] = any_pos();
        return it;
    endfunction

    function automatic drive_item_t tick_of(longint a, longint b, longint c,
                                            longint d, longint e, longint f);
        drive_item_t it;
        it.command = CMD_TICK;
        it.target  = any_pos();
        it.pos[0]  = fit_pos(a);
        it.pos[1]  = fit_pos(b);
        it.pos[2]  = fit_pos(c);
        it.pos[3]  = fit_pos(d);
        it.pos[4]  = fit_pos(e);
        it.pos[5]  = fit_pos(f);
        return it;
    endfunction

    // Tick with every encoder near one distance.
    function automatic drive_item_t tick_near(longint center, int jitter);
        drive_item_t it;
        it.command = CMD_TICK;
        it.target  = any_pos();
        for (int i = 0; i < INPUT_POS_COUNT; i++)
            it.pos[i] = fit_pos(center + int'($urandom_range(0, 2 * jitter)) - jitter);
        return it;
    endfunction

    task automatic push_item(drive_item_t it);
        move_item_q.push_back(it);
        items_queued++;
    endtask

    // Waits until every queued word is taken and every result has arrived.
    task automatic wait_idle();
        do @(negedge clk);
        while (items_taken != items_queued || drive_expect_q.size() != 0);
    endtask

    // One register write; also updates the shadow copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do @(negedge clk);
        while (!cfg_accepted);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_GAIN_P:            reg_shadow.gain_p            = word[GAIN_W-1:0];
            REG_GAIN_I:            reg_shadow.gain_i            = word[GAIN_W-1:0];
            REG_GAIN_D:            reg_shadow.gain_d            = word[GAIN_W-1:0];
            REG_SLEW_STEP:         reg_shadow.slew_step         = word[SLEW_W-1:0];
            REG_INTEGRAL_LIMIT:    reg_shadow.integral_limit    = word[LIMIT_W-1:0];
            REG_SETTLE_ERROR:      reg_shadow.settle_error      = word[SETTLE_W-1:0];
            REG_SETTLE_PREV_ERROR: reg_shadow.settle_prev_error = word[SETTLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int unsigned gp, int unsigned gi, int unsigned gd,
                             int unsigned slew, int unsigned lim,
                             int unsigned se, int unsigned spe);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_SLEW_STEP, slew);
        write_reg(REG_INTEGRAL_LIMIT, lim);
        write_reg(REG_SETTLE_ERROR, se);
        write_reg(REG_SETTLE_PREV_ERROR, spe);
    endtask

    // A move: begin, ticks closing on the target with encoder jitter, then up to
    // three ticks parked near the target so that the move may settle.
    task automatic queue_move();
        longint tgt;
        longint start;
        int     ticks;
        int     jitter;
        int     tail;
        if ($urandom_range(3) == 0)
            tgt = longint'(signed'(any_pos()));
        else
            tgt = int'($urandom_range(0, 60000)) - 30000;
        start  = tgt + int'($urandom_range(0, 12000)) - 6000;
        ticks  = $urandom_range(2, 24);
        jitter = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
        tail   = $urandom_range(0, 3);
        push_item(begin_item(tgt));
        for (int k = 0; k < ticks; k++)
            push_item(tick_near(start + (tgt - start) * (k + 1) / ticks, jitter));
        for (int k = 0; k < tail; k++)
            push_item(tick_near(tgt, $urandom_range(0, 1)));
    endtask

    // Stray word with every field at random.
    task automatic queue_noise();
        drive_item_t it;
        it.command = command_t'($urandom_range(1));
        it.target  = any_pos();
        for (int i = 0; i < INPUT_POS_COUNT; i++)
            it.pos[i] = any_pos();
        push_item(it);
    endtask

    task automatic run_phase(int quota, int mode, bit pause_midway, bit long_hold);
        int unsigned base;
        bit          paused;
        base   = items_queued;
        paused = 1'b0;
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
        if (long_hold)
            stall_requests++;
        while (items_queued - base < quota)
        begin
            if (pause_midway && !paused && items_queued - base >= quota / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85)
                queue_move();
            else
                queue_noise();
        end
        wait_idle();
    endtask

    initial
    begin : run_test
        in_ch.valid           = 1'b0;
        in_ch.command         = CMD_BEGIN;
        in_ch.target          = '0;
        in_ch.pos_front_left  = '0;
        in_ch.pos_front_right = '0;
        in_ch.pos_mid_left    = '0;
        in_ch.pos_mid_right   = '0;
        in_ch.pos_back_left   = '0;
        in_ch.pos_back_right  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        out_ch.ready          = 1'b0;
        rst_n                 = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed words at reset settings: tick while idle, field extremes,
        // truncating average, integral held at its limit, settling and done hold.
        push_item(tick_near(0, 0));
        push_item(begin_item(POS_MAX));
        push_item(tick_near(POS_MIN, 0));
        push_item(tick_near(POS_MAX, 0));
        push_item(begin_item(POS_MIN));
        push_item(tick_near(POS_MAX, 0));
        push_item(tick_of(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN));
        push_item(begin_item(0));
        push_item(tick_of(-1, -1, -1, -1, -1, 0));
        push_item(tick_near(0, 0));
        push_item(begin_item(1000));
        repeat (5) push_item(tick_near(0, 0));
        push_item(tick_near(990, 0));
        push_item(tick_near(1000, 0));
        push_item(tick_near(1000, 0));
        push_item(begin_item(0));
        push_item(tick_of(1, 1, 1, 1, 1, 0));
        wait_idle();

        // Rounding ties and floor division of negative power.
        write_all(65536, 0, 0, 65536, 0, 0, 0);
        push_item(begin_item(1));
        push_item(tick_near(0, 0));
        push_item(begin_item(-1));
        push_item(tick_near(0, 0));
        wait_idle();
        write_reg(REG_GAIN_P, 65535);
        write_reg(REG_SPARE_INDEX, 20'hFFFFF);
        push_item(begin_item(1));
        push_item(tick_near(0, 0));
        push_item(begin_item(-1));
        push_item(tick_near(0, 0));
        wait_idle();

        // Random phases over several register settings and idle patterns.
        write_all(3375, 754, 32768, 6554, 3200, 12, 16);
        run_phase(300, 0, 1'b0, 1'b0);
        write_all(1048575, 1048575, 1048575, 65536, 1048575, 65535, 65535);
        run_phase(250, 1, 1'b0, 1'b0);
        write_all(0, 0, 0, 0, 0, 0, 0);
        run_phase(150, 2, 1'b0, 1'b1);
        write_all($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                  $urandom_range(0, 1048575), $urandom_range(0, 65536),
                  $urandom_range(0, 1048575), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        run_phase(250, 3, 1'b0, 1'b0);
        write_all($urandom_range(0, 20000), $urandom_range(0, 5000),
                  $urandom_range(0, 65536), $urandom_range(1, 20000),
                  $urandom_range(100, 10000), $urandom_range(1, 64),
                  $urandom_range(1, 64));
        run_phase(300, 0, 1'b1, 1'b0);
        write_all($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                  $urandom_range(0, 1048575), $urandom_range(0, 65536),
                  $urandom_range(0, 1048575), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        run_phase(250, 1, 1'b0, 1'b0);
        write_all(3375, 754, 32768, 6554, 3200, 12, 16);
        run_phase(250, 3, 1'b0, 1'b0);

        // Let the pipeline empty, watching for stray result words.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && drive_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard limit on the run time.
    initial
    begin : watchdog
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pdws_pkg.sv
rtl/pdws_in_if.sv
rtl/pdws_out_if.sv
rtl/pdws_cfg_if.sv
rtl/pid_position_drive_with_slew_unit.sv
tb/sv/tb.sv
